/* rtl/dcc_pkg.sv */
// Shared widths, calendar tables and leap-year helpers for the day count converter.
package dcc_pkg;

   // Accumulator width: the largest alarm sum (255 years plus a year's worth) fits in 17 bits.
   localparam int ACC_W   = 17;
   localparam int DC_W    = 16;
   localparam int YEAR_W  = 8;
   localparam int MONTH_W = 4;
   localparam int DAY_W   = 5;
   localparam int DOM_W   = 6;
   localparam int WIN_W   = 5;
   localparam int CUM_W   = 9;

   localparam logic [MONTH_W-1:0] LAST_MONTH   = 4'd11;
   localparam logic [WIN_W-1:0]   WINDOW_RESET = 5'd31;
   localparam logic [CUM_W-1:0]   DAYS_COMMON  = 9'd365;
   localparam logic [CUM_W-1:0]   DAYS_LEAP    = 9'd366;

   // Commands carried by one item.
   localparam logic CMD_TO_DATE  = 1'b0;
   localparam logic CMD_TO_ALARM = 1'b1;

   // Gregorian rule for years 1900 through 2155: every fourth year is a leap year,
   // except 1900 and 2100. The year 2000 is divisible by 400 and stays a leap year.
   function automatic logic is_leap(input logic [YEAR_W-1:0] yr);
      is_leap = (yr[1:0] == 2'b00) && (yr != 8'd0) && (yr != 8'd200);
   endfunction

   function automatic logic [CUM_W-1:0] year_days(input logic [YEAR_W-1:0] yr);
      year_days = is_leap(yr) ? DAYS_LEAP : DAYS_COMMON;
   endfunction

   // Days before the first of a month; index 12 gives the length of the year.
   function automatic logic [CUM_W-1:0] cum_days(input logic leap, input logic [MONTH_W-1:0] idx);
      logic [CUM_W-1:0] base;
      unique case (idx)
         4'd0:    base = 9'd0;
         4'd1:    base = 9'd31;
         4'd2:    base = 9'd59;
         4'd3:    base = 9'd90;
         4'd4:    base = 9'd120;
         4'd5:    base = 9'd151;
         4'd6:    base = 9'd181;
         4'd7:    base = 9'd212;
         4'd8:    base = 9'd243;
         4'd9:    base = 9'd273;
         4'd10:   base = 9'd304;
         4'd11:   base = 9'd334;
         4'd12:   base = 9'd365;
         default: base = 9'd0;
      endcase
      cum_days = base + CUM_W'(leap && (idx >= 4'd2));
   endfunction

endpackage

/* rtl/day_count_calendar_converter.sv */
// Day count to calendar date converter and alarm date checker, top level.
// A day-count item strips whole years, then steps through the months, then forms the day;
// an alarm item sums the years before its year, adds month offset and day, then checks it.
// Busy is high from acceptance until the result strobe; an alarm with a nonexistent month
// is answered in the next cycle. The single shared add/subtract unit sets the loop count.
// Synchronous active-high reset returns to idle, drops the strobe and sets the window to 31.
// The result is shown for exactly one cycle on rsp_valid; the receiver cannot stall it.
module day_count_calendar_converter #(
   parameter int DAY_COUNT_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   // Command channel.
   input  logic                         start,
   output logic                         busy,
   input  logic                         req_command,
   input  logic [dcc_pkg::DC_W-1:0]     req_day_count,
   input  logic [dcc_pkg::YEAR_W-1:0]   req_year,
   input  logic [dcc_pkg::MONTH_W-1:0]  req_month,
   input  logic [dcc_pkg::DOM_W-1:0]    req_day_of_month,
   // Result channel.
   output logic                         rsp_valid,
   output logic [dcc_pkg::YEAR_W-1:0]   rsp_out_year,
   output logic [dcc_pkg::MONTH_W-1:0]  rsp_out_month,
   output logic [dcc_pkg::DAY_W-1:0]    rsp_out_day,
   output logic [dcc_pkg::DC_W-1:0]     rsp_alarm_day_count,
   output logic                         rsp_alarm_ok,
   // Alarm window register write.
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [dcc_pkg::WIN_W-1:0]    csr_wdata
);

   // The compare width covers both the accumulator and the configured day count range.
   localparam int CMP_W = (DAY_COUNT_BITS > dcc_pkg::ACC_W) ? DAY_COUNT_BITS : dcc_pkg::ACC_W;
   localparam logic [CMP_W-1:0] DAY_MASK = CMP_W'((64'd1 << DAY_COUNT_BITS) - 64'd1);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_YEAR,
      ST_MONTH,
      ST_DAY,
      ST_ACCUM,
      ST_ADD_CUM,
      ST_ADD_DOM,
      ST_DEC,
      ST_CHECK
   } state_type;

   state_type                     state_ff, state_in;
   logic                          cmd_ff, cmd_in;
   logic [dcc_pkg::ACC_W-1:0]     acc_ff, acc_in;
   logic [dcc_pkg::YEAR_W-1:0]    yr_ff, yr_in;
   logic [dcc_pkg::YEAR_W-1:0]    tgt_ff, tgt_in;
   logic [dcc_pkg::MONTH_W-1:0]   m_ff, m_in;
   logic [dcc_pkg::MONTH_W-1:0]   mo_ff, mo_in;
   logic [dcc_pkg::DOM_W-1:0]     dom_ff, dom_in;
   logic [dcc_pkg::DC_W-1:0]      cur_ff, cur_in;
   logic [dcc_pkg::WIN_W-1:0]     win_ff, win_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [dcc_pkg::YEAR_W-1:0]    rsp_year_ff, rsp_year_in;
   logic [dcc_pkg::MONTH_W-1:0]   rsp_month_ff, rsp_month_in;
   logic [dcc_pkg::DAY_W-1:0]     rsp_day_ff, rsp_day_in;
   logic [dcc_pkg::DC_W-1:0]      rsp_alarm_ff, rsp_alarm_in;
   logic                          rsp_ok_ff, rsp_ok_in;

   // Shared add/subtract unit. On a subtract the carry out is high when a >= b.
   logic [dcc_pkg::ACC_W-1:0]     unit_a, unit_b, unit_b_eff, unit_res;
   logic                          unit_sub, unit_carry;
   logic                          accept;
   logic                          month_leap;
   logic [dcc_pkg::DC_W-1:0]      cur_masked;
   logic                          overflow;
   logic                          in_window;

   assign accept     = start && !busy;
   assign busy       = (state_ff != ST_IDLE);
   assign csr_ready  = 1'b1;
   assign cur_masked = req_day_count & DAY_MASK[dcc_pkg::DC_W-1:0];

   // During the month search the leap flag belongs to the year that was reached; while
   // building an alarm count the year counter has stopped on the alarm year.
   assign month_leap = dcc_pkg::is_leap(yr_ff);

   // Operand selection for the shared unit, one operation per sequencer state.
   always_comb begin
      unit_a   = acc_ff;
      unit_b   = '0;
      unit_sub = 1'b0;
      unique case (state_ff)
         ST_YEAR: begin
            unit_b   = dcc_pkg::ACC_W'(dcc_pkg::year_days(yr_ff));
            unit_sub = 1'b1;
         end
         ST_MONTH: begin
            unit_b   = dcc_pkg::ACC_W'(dcc_pkg::cum_days(month_leap, m_ff + 4'd1));
            unit_sub = 1'b1;
         end
         ST_DAY: begin
            unit_b   = dcc_pkg::ACC_W'(dcc_pkg::cum_days(month_leap, m_ff));
            unit_sub = 1'b1;
         end
         ST_ACCUM: begin
            unit_b   = dcc_pkg::ACC_W'(dcc_pkg::year_days(yr_ff));
         end
         ST_ADD_CUM: begin
            unit_b   = dcc_pkg::ACC_W'(dcc_pkg::cum_days(month_leap, mo_ff));
         end
         ST_ADD_DOM: begin
            unit_b   = dcc_pkg::ACC_W'(dom_ff);
         end
         ST_DEC: begin
            unit_b   = dcc_pkg::ACC_W'(1);
            unit_sub = 1'b1;
         end
         ST_CHECK: begin
            unit_b   = dcc_pkg::ACC_W'(cur_ff);
            unit_sub = 1'b1;
         end
         default: begin
            unit_b   = '0;
         end
      endcase
   end

   assign unit_b_eff = unit_sub ? ~unit_b : unit_b;
   assign {unit_carry, unit_res} = {1'b0, unit_a} + {1'b0, unit_b_eff}
                                 + (dcc_pkg::ACC_W + 1)'(unit_sub);

   // In the check step the accumulator holds the alarm count and the unit gives
   // alarm minus current day; the window test needs a non-negative gap no larger than the window.
   assign overflow  = CMP_W'(acc_ff) > DAY_MASK;
   assign in_window = unit_carry
                   && (unit_res[dcc_pkg::ACC_W-1:dcc_pkg::WIN_W] == '0)
                   && (unit_res[dcc_pkg::WIN_W-1:0] <= win_ff);

   // Sequencer and next-value logic.
   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      acc_in       = acc_ff;
      yr_in        = yr_ff;
      tgt_in       = tgt_ff;
      m_in         = m_ff;
      mo_in        = mo_ff;
      dom_in       = dom_ff;
      cur_in       = cur_ff;
      win_in       = win_ff;
      rsp_valid_in = 1'b0;
      rsp_year_in  = rsp_year_ff;
      rsp_month_in = rsp_month_ff;
      rsp_day_in   = rsp_day_ff;
      rsp_alarm_in = rsp_alarm_ff;
      rsp_ok_in    = rsp_ok_ff;

      if (csr_valid && csr_ready) begin
         win_in = csr_wdata;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd_in = req_command;
               cur_in = cur_masked;
               tgt_in = req_year;
               mo_in  = req_month;
               dom_in = req_day_of_month;
               yr_in  = '0;
               m_in   = '0;
               if (req_command == dcc_pkg::CMD_TO_DATE) begin
                  acc_in   = dcc_pkg::ACC_W'(cur_masked);
                  state_in = ST_YEAR;
               end else if (req_month > dcc_pkg::LAST_MONTH) begin
                  // A month that does not exist gives an empty alarm at once.
                  rsp_valid_in = 1'b1;
                  rsp_year_in  = '0;
                  rsp_month_in = '0;
                  rsp_day_in   = '0;
                  rsp_alarm_in = '0;
                  rsp_ok_in    = 1'b0;
               end else begin
                  acc_in   = '0;
                  state_in = ST_ACCUM;
               end
            end
         end
         ST_YEAR: begin
            // Strip whole years while the remainder still covers the current one.
            if (unit_carry) begin
               acc_in = unit_res;
               yr_in  = yr_ff + 8'd1;
            end else begin
               state_in = ST_MONTH;
            end
         end
         ST_MONTH: begin
            if ((m_ff < dcc_pkg::LAST_MONTH) && unit_carry) begin
               m_in = m_ff + 4'd1;
            end else begin
               state_in = ST_DAY;
            end
         end
         ST_DAY: begin
            rsp_valid_in = 1'b1;
            rsp_year_in  = yr_ff;
            rsp_month_in = m_ff;
            rsp_day_in   = unit_res[dcc_pkg::DAY_W-1:0] + 5'd1;
            rsp_alarm_in = '0;
            rsp_ok_in    = 1'b0;
            state_in     = ST_IDLE;
         end
         ST_ACCUM: begin
            // Sum the lengths of all years before the alarm year.
            if (yr_ff == tgt_ff) begin
               state_in = ST_ADD_CUM;
            end else begin
               acc_in = unit_res;
               yr_in  = yr_ff + 8'd1;
            end
         end
         ST_ADD_CUM: begin
            acc_in   = unit_res;
            state_in = ST_ADD_DOM;
         end
         ST_ADD_DOM: begin
            acc_in   = unit_res;
            state_in = ST_DEC;
         end
         ST_DEC: begin
            if (acc_ff == '0) begin
               // Day zero of January 1900 falls before the epoch.
               rsp_valid_in = 1'b1;
               rsp_year_in  = '0;
               rsp_month_in = '0;
               rsp_day_in   = '0;
               rsp_alarm_in = '0;
               rsp_ok_in    = 1'b0;
               state_in     = ST_IDLE;
            end else begin
               acc_in   = unit_res;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            rsp_valid_in = 1'b1;
            rsp_year_in  = '0;
            rsp_month_in = '0;
            rsp_day_in   = '0;
            if (overflow) begin
               rsp_alarm_in = DAY_MASK[dcc_pkg::DC_W-1:0];
               rsp_ok_in    = 1'b0;
            end else begin
               rsp_alarm_in = acc_ff[dcc_pkg::DC_W-1:0];
               rsp_ok_in    = in_window;
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State, working registers and registered result outputs.
   always_ff @(posedge clock) begin
      state_ff     <= state_in;
      cmd_ff       <= cmd_in;
      acc_ff       <= acc_in;
      yr_ff        <= yr_in;
      tgt_ff       <= tgt_in;
      m_ff         <= m_in;
      mo_ff        <= mo_in;
      dom_ff       <= dom_in;
      cur_ff       <= cur_in;
      win_ff       <= win_in;
      rsp_valid_ff <= rsp_valid_in;
      rsp_year_ff  <= rsp_year_in;
      rsp_month_ff <= rsp_month_in;
      rsp_day_ff   <= rsp_day_in;
      rsp_alarm_ff <= rsp_alarm_in;
      rsp_ok_ff    <= rsp_ok_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         win_ff       <= dcc_pkg::WINDOW_RESET;
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_out_year        = rsp_year_ff;
   assign rsp_out_month       = rsp_month_ff;
   assign rsp_out_day         = rsp_day_ff;
   assign rsp_alarm_day_count = rsp_alarm_ff;
   assign rsp_alarm_ok        = rsp_ok_ff;

`ifndef SYNTHESIS
   // The strobe only fires while the sequencer is idle.
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while sequencer busy");

   // An accepted item either starts the sequencer or is answered in the next cycle.
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      accept |=> (busy || rsp_valid))
      else $error("accepted item neither started nor answered");

   // A date result leaves the alarm fields clear and names a real month and day.
   a_date_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (cmd_ff == dcc_pkg::CMD_TO_DATE)) |->
         (!rsp_alarm_ok && (rsp_alarm_day_count == '0)
          && (rsp_out_month <= dcc_pkg::LAST_MONTH) && (rsp_out_day != '0)))
      else $error("malformed date result");

   // An alarm result never carries date fields.
   a_alarm_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (cmd_ff == dcc_pkg::CMD_TO_ALARM)) |->
         ((rsp_out_year == '0) && (rsp_out_month == '0) && (rsp_out_day == '0)))
      else $error("alarm result carries date fields");
`endif

endmodule
